// File: hdl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the sorted top-k candidate list
// Entry width, list depth, command codes and the control/status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 5;
    localparam int RANK_W     = 4;
    localparam int CMD_W      = 2;

    localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(16);
    localparam logic [DATA_W-1:0] EMPTY_DIST = '1;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic insert;
        logic clear;
        logic rd_start;
        logic rd_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic rd_last;
    } dp_status_t;

endpackage

// File: hdl/stk_ctrl.sv
// ----------------------------------------------------------------------------
// stk_ctrl: command sequencer
// Decodes accepted commands and steps the datapath through a read-out run.
// ----------------------------------------------------------------------------
module stk_ctrl
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [stk_pkg::CMD_W-1:0] cmd,
    input  stk_pkg::dp_status_t      status,
    output stk_pkg::ctl_cmd_t        ctl,
    output logic                     busy
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == ST_READ);
    assign accept = start && !busy;

    always_comb
    begin
        ctl          = '0;
        ctl.insert   = accept && (cmd == stk_pkg::CMD_INSERT);
        ctl.clear    = accept && (cmd == stk_pkg::CMD_CLEAR);
        ctl.rd_start = accept && (cmd == stk_pkg::CMD_READ);
        ctl.rd_step  = (state_reg == ST_READ);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == stk_pkg::CMD_READ))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // leave after the final entry has been issued
                if (status.rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hdl/stk_datapath.sv
// ----------------------------------------------------------------------------
// stk_datapath: sorted entry cells, length register and read-out registers
// Each cell compares the candidate against its own distance; the insert
// point and the shift are settled combinationally across all cells.
// ----------------------------------------------------------------------------
module stk_datapath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  stk_pkg::ctl_cmd_t           ctl,
    output stk_pkg::dp_status_t         status,
    input  logic                        cfg_valid,
    input  logic [stk_pkg::LEN_W-1:0]   cfg_data,
    input  logic [stk_pkg::DATA_W-1:0]  item_id,
    input  logic [stk_pkg::DATA_W-1:0]  distance,
    input  logic [stk_pkg::DATA_W-1:0]  leaf_number,
    output logic                        strobe,
    output logic [stk_pkg::RANK_W-1:0]  rank,
    output logic [stk_pkg::DATA_W-1:0]  entry_id,
    output logic [stk_pkg::DATA_W-1:0]  entry_distance,
    output logic [stk_pkg::DATA_W-1:0]  entry_leaf,
    output logic                        last
);

    localparam int D = stk_pkg::LIST_DEPTH;

    logic [stk_pkg::DATA_W-1:0] id_reg   [D];
    logic [stk_pkg::DATA_W-1:0] dist_reg [D];
    logic [stk_pkg::DATA_W-1:0] leaf_reg [D];
    logic [stk_pkg::DATA_W-1:0] id_next   [D];
    logic [stk_pkg::DATA_W-1:0] dist_next [D];
    logic [stk_pkg::DATA_W-1:0] leaf_next [D];

    logic [stk_pkg::LEN_W-1:0]  len_reg;
    logic [stk_pkg::CNT_W-1:0]  used_len;
    logic [stk_pkg::IDX_W-1:0]  ptr_reg;
    logic [stk_pkg::IDX_W-1:0]  ptr_next;
    logic                       ptr_last;

    logic [D-1:0] in_use;
    logic [D-1:0] pass;
    logic [D-1:0] take;

    logic                        strobe_reg;
    logic [stk_pkg::RANK_W-1:0]  rank_reg;
    logic [stk_pkg::DATA_W-1:0]  out_id_reg;
    logic [stk_pkg::DATA_W-1:0]  out_dist_reg;
    logic [stk_pkg::DATA_W-1:0]  out_leaf_reg;
    logic                        last_reg;

    // clamp the programmed length into 1..depth
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            used_len = stk_pkg::CNT_W'(1);
        end
        else if (32'(len_reg) > D)
        begin
            used_len = stk_pkg::CNT_W'(D);
        end
        else
        begin
            used_len = stk_pkg::CNT_W'(len_reg);
        end
    end

    // a cell moves when it and every in-use cell at a higher index hold a larger distance than the candidate
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            in_use[i] = (32'(used_len) > i);
            pass[i]   = !in_use[i] || (distance < dist_reg[i]);
        end
        for (int i = 0; i < D; i++)
        begin
            take[i] = in_use[i] && (&(pass | ((D'(1) << i) - D'(1))));
        end
    end

    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            id_next[i]   = id_reg[i];
            dist_next[i] = dist_reg[i];
            leaf_next[i] = leaf_reg[i];
            if (ctl.clear)
            begin
                dist_next[i] = stk_pkg::EMPTY_DIST;
            end
            else if (ctl.insert && take[i])
            begin
                if (i > 0 && take[(i > 0) ? i - 1 : 0])
                begin
                    id_next[i]   = id_reg[(i > 0) ? i - 1 : 0];
                    dist_next[i] = dist_reg[(i > 0) ? i - 1 : 0];
                    leaf_next[i] = leaf_reg[(i > 0) ? i - 1 : 0];
                end
                else
                begin
                    id_next[i]   = item_id;
                    dist_next[i] = distance;
                    leaf_next[i] = leaf_number;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < D; i++)
            begin
                id_reg[i]   <= '0;
                dist_reg[i] <= stk_pkg::EMPTY_DIST;
                leaf_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < D; i++)
            begin
                id_reg[i]   <= id_next[i];
                dist_reg[i] <= dist_next[i];
                leaf_reg[i] <= leaf_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= stk_pkg::LEN_RESET;
        end
        else if (cfg_valid)
        begin
            len_reg <= cfg_data;
        end
    end

    // read pointer
    assign ptr_last       = ((stk_pkg::CNT_W'(ptr_reg) + stk_pkg::CNT_W'(1)) == used_len);
    assign status.rd_last = ptr_last;

    always_comb
    begin
        ptr_next = ptr_reg;
        if (ctl.rd_start)
        begin
            ptr_next = '0;
        end
        else if (ctl.rd_step)
        begin
            ptr_next = stk_pkg::IDX_W'(ptr_reg + stk_pkg::IDX_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            ptr_reg    <= ptr_next;
            strobe_reg <= ctl.rd_step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_step)
        begin
            rank_reg     <= stk_pkg::RANK_W'(ptr_reg);
            out_id_reg   <= id_reg[ptr_reg];
            out_dist_reg <= dist_reg[ptr_reg];
            out_leaf_reg <= leaf_reg[ptr_reg];
            last_reg     <= ptr_last;
        end
    end

    assign strobe         = strobe_reg;
    assign rank           = rank_reg;
    assign entry_id       = out_id_reg;
    assign entry_distance = out_dist_reg;
    assign entry_leaf     = out_leaf_reg;
    assign last           = last_reg;

endmodule

// File: hdl/sorted_top_k_insert_tagged_core.sv
// ----------------------------------------------------------------------------
// sorted_top_k_insert_tagged_core: sorted top-k candidate list
// Keeps the best candidates in ascending distance order; inserts, clears
// and reads out the list on command.
//
//   channel   signals                                       handshake
//   command   cmd, item_id, distance, leaf_number           start && !busy
//   config    cfg_data (list length)                        cfg_valid && cfg_ready
//   result    rank, entry_id, entry_distance, entry_leaf,   strobe, one cycle
//             last
//
// Insert and clear leave busy low, so one can follow every cycle. Read holds
// busy until the last entry of the used length (list_length clamped to 1..16)
// has been issued, one entry per cycle from the read pointer; results appear in
// the cycle after issue, via the output registers. Reset restores length 16
// and an all-empty list. The receiver cannot stall: each strobe is one transfer.
// ----------------------------------------------------------------------------
module sorted_top_k_insert_tagged_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [stk_pkg::CMD_W-1:0]   cmd,
    input  logic [stk_pkg::DATA_W-1:0]  item_id,
    input  logic [stk_pkg::DATA_W-1:0]  distance,
    input  logic [stk_pkg::DATA_W-1:0]  leaf_number,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [stk_pkg::LEN_W-1:0]   cfg_data,
    output logic                        strobe,
    output logic [stk_pkg::RANK_W-1:0]  rank,
    output logic [stk_pkg::DATA_W-1:0]  entry_id,
    output logic [stk_pkg::DATA_W-1:0]  entry_distance,
    output logic [stk_pkg::DATA_W-1:0]  entry_leaf,
    output logic                        last
);

    stk_pkg::ctl_cmd_t   ctl;
    stk_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    stk_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .status (status),
        .ctl    (ctl),
        .busy   (busy)
    );

    stk_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .status         (status),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .item_id        (item_id),
        .distance       (distance),
        .leaf_number    (leaf_number),
        .strobe         (strobe),
        .rank           (rank),
        .entry_id       (entry_id),
        .entry_distance (entry_distance),
        .entry_leaf     (entry_leaf),
        .last           (last)
    );

`ifndef SYNTHESIS
    a_read_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == stk_pkg::CMD_READ)) |=> busy)
        else $error("read command did not raise busy");

    a_no_strobe_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |=> !strobe)
        else $error("result transfer without a read in progress");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("final entry issued while still busy");

    a_busy_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe)
        else $error("read cycle issued no entry");
`endif

endmodule
